@@ rtl/core/tcce_pkg.sv @@
// Shared constants, codes and control/status types for the text console cursor engine.
// Depends on nothing; every other file of the block but tcce_ram takes what it needs from here.
`default_nettype none

package tcce_pkg;

	// Screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS     = ROWS * COLUMNS;

	// Internal widths follow the geometry
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int TAB_STOPS = (COLUMNS - 1) / TAB_WIDTH;

	// Port field widths are fixed by the interface
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;
	localparam int IDX_FIELD_W = 11;
	localparam int CHAR_W      = 8;
	localparam int FG_W        = 4;
	localparam int BG_W        = 3;
	localparam int CELL_W      = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	// Commands
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd126;
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CHAR_HT    = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_FF    = 8'd12;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

	// Result cell source
	localparam logic [1:0] CELL_KEEP  = 2'd0;
	localparam logic [1:0] CELL_ZERO  = 2'd1;
	localparam logic [1:0] CELL_BLANK = 2'd2;
	localparam logic [1:0] CELL_RAM   = 2'd3;

	typedef struct packed {
		logic       load_item;
		logic       fill_step;
		logic       write_cell;
		logic       apply_put;
		logic       read_issue;
		logic [1:0] cell_sel;
		logic       load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_printable;
		logic row_valid;
		logic read_in_range;
		logic read_row_valid;
		logic fill_last;
		logic out_free;
	} dp_status_t;

	// Next tab stop after col; COLUMNS when no stop remains on the line
	function automatic logic [COL_W:0] next_tab(input logic [COL_W-1:0] col);
		logic [COL_W:0] dest;
		dest = (COL_W + 1)'(COLUMNS);
		for (int k = TAB_STOPS; k >= 1; k--) begin
			if (k * TAB_WIDTH > int'(col)) begin
				dest = (COL_W + 1)'(k * TAB_WIDTH);
			end
		end
		return dest;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: joins controller and datapath.
// Depends on tcce_pkg, tcce_ctrl, tcce_datapath (and through it tcce_ram).
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------------
//   item     | item_valid / item_stall   | command, char_code, foreground, background,
//            |                           | read_row, read_column
//   result   | result_valid/result_stall | cursor_row, cursor_column, cursor_index,
//            |                           | cell_data
//
// One item at a time. A printable byte goes through the decode, cell write and result
// states; other puts and reads of blank or out-of-range cells go from decode straight to
// the result state; a read of a written row goes through decode, a read wait for the
// registered store read, and result. The first printable byte written into a row since
// reset, form feed or scroll blanks the row first, through the single store write port.
// Scroll and form feed themselves are immediate: a rotating row offset and per-row
// valid bits stand in for moving or clearing the store, so reset needs no clearing pass.
// A stalled result holds; the next item is taken once the engine is idle, and its result
// waits in the result state until the previous transaction is taken.
`default_nettype none

module text_console_cursor_engine (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	output logic                                       item_stall,
	input  wire logic                                  command,
	input  wire logic [tcce_pkg::CHAR_W-1:0]           char_code,
	input  wire logic [tcce_pkg::FG_W-1:0]             foreground,
	input  wire logic [tcce_pkg::BG_W-1:0]             background,
	input  wire logic [tcce_pkg::ROW_FIELD_W-1:0]      read_row,
	input  wire logic [tcce_pkg::COL_FIELD_W-1:0]      read_column,
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output logic      [tcce_pkg::ROW_FIELD_W-1:0]      cursor_row,
	output logic      [tcce_pkg::COL_FIELD_W-1:0]      cursor_column,
	output logic      [tcce_pkg::IDX_FIELD_W-1:0]      cursor_index,
	output logic      [tcce_pkg::CELL_W-1:0]           cell_data
);

	tcce_pkg::ctrl_cmd_t  cmd;
	tcce_pkg::dp_status_t status;
	logic                 busy;

	// Hold off new transactions until the current one has reached the result register
	assign item_stall = busy;

	tcce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.busy       (busy),
		.status     (status),
		.cmd        (cmd)
	);

	tcce_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.command       (command),
		.char_code     (char_code),
		.foreground    (foreground),
		.background    (background),
		.read_row      (read_row),
		.read_column   (read_column),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.cursor_index  (cursor_index),
		.cell_data     (cell_data)
	);

endmodule

`default_nettype wire

@@ rtl/core/tcce_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tcce_ctrl.sv @@
// Controller state machine of the console engine: sequences decode, row blanking,
// cell write, cell read and result hand-over. Depends on tcce_pkg.
`default_nettype none

module tcce_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        busy,
	input  wire tcce_pkg::dp_status_t   status,
	output tcce_pkg::ctrl_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DECODE    = 3'd1;
	localparam logic [2:0] ST_FILL      = 3'd2;
	localparam logic [2:0] ST_WRITE     = 3'd3;
	localparam logic [2:0] ST_READ_WAIT = 3'd4;
	localparam logic [2:0] ST_RESULT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.is_read) begin
					if (status.read_in_range && status.read_row_valid) begin
						cmd.read_issue = 1'b1;
						state_nxt      = ST_READ_WAIT;
					end else begin
						cmd.cell_sel = status.read_in_range ? tcce_pkg::CELL_BLANK
						                                    : tcce_pkg::CELL_ZERO;
						state_nxt    = ST_RESULT;
					end
				end else begin
					cmd.cell_sel = tcce_pkg::CELL_ZERO;
					if (status.is_printable) begin
						state_nxt = status.row_valid ? ST_WRITE : ST_FILL;
					end else begin
						cmd.apply_put = 1'b1;
						state_nxt     = ST_RESULT;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_cell = 1'b1;
				cmd.apply_put  = 1'b1;
				state_nxt      = ST_RESULT;
			end
			ST_READ_WAIT: begin
				cmd.cell_sel = tcce_pkg::CELL_RAM;
				state_nxt    = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.load_result = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tcce_datapath.sv @@
// Datapath of the console engine: captured item, cursor, scroll offset, row valid
// bits, row blanking counter, cell store and result register. Depends on tcce_pkg, tcce_ram.
`default_nettype none

module tcce_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tcce_pkg::ctrl_cmd_t                   cmd,
	output tcce_pkg::dp_status_t                       status,
	input  wire logic                                  command,
	input  wire logic [tcce_pkg::CHAR_W-1:0]           char_code,
	input  wire logic [tcce_pkg::FG_W-1:0]             foreground,
	input  wire logic [tcce_pkg::BG_W-1:0]             background,
	input  wire logic [tcce_pkg::ROW_FIELD_W-1:0]      read_row,
	input  wire logic [tcce_pkg::COL_FIELD_W-1:0]      read_column,
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output logic      [tcce_pkg::ROW_FIELD_W-1:0]      cursor_row,
	output logic      [tcce_pkg::COL_FIELD_W-1:0]      cursor_column,
	output logic      [tcce_pkg::IDX_FIELD_W-1:0]      cursor_index,
	output logic      [tcce_pkg::CELL_W-1:0]           cell_data
);

	localparam int CW    = tcce_pkg::COL_W;
	localparam int RW    = tcce_pkg::ROW_W;
	localparam int AW    = tcce_pkg::ADDR_W;
	localparam int ROWS  = tcce_pkg::ROWS;
	localparam int COLS  = tcce_pkg::COLUMNS;
	localparam int RFW   = tcce_pkg::ROW_FIELD_W;
	localparam int CFW   = tcce_pkg::COL_FIELD_W;
	localparam int IFW   = tcce_pkg::IDX_FIELD_W;

	// Captured item
	logic                           command_q;
	logic [tcce_pkg::CHAR_W-1:0]    char_q;
	logic [tcce_pkg::FG_W-1:0]      fg_q;
	logic [tcce_pkg::BG_W-1:0]      bg_q;
	logic [RFW-1:0]                 rrow_q;
	logic [CFW-1:0]                 rcol_q;

	// Cursor and store bookkeeping
	logic [RW-1:0]                  row_q;
	logic [CW-1:0]                  col_q;
	logic [RW-1:0]                  top_q;
	logic [ROWS-1:0]                row_valid_q;
	logic [CW-1:0]                  fill_q;
	logic [tcce_pkg::CELL_W-1:0]    cell_q;
	logic                           result_valid_q;
	logic [RFW-1:0]                 res_row_q;
	logic [CFW-1:0]                 res_col_q;
	logic [IFW-1:0]                 res_idx_q;
	logic [tcce_pkg::CELL_W-1:0]    res_cell_q;

	logic [RW-1:0]                  cur_phys;
	logic [RW-1:0]                  rd_phys;
	logic                           rd_in_range;
	logic [AW-1:0]                  row_base;
	logic [AW-1:0]                  waddr;
	logic [AW-1:0]                  raddr;
	logic [tcce_pkg::CELL_W-1:0]    wdata;
	logic [tcce_pkg::CELL_W-1:0]    rdata;
	logic                           we;
	logic                           printable;
	logic [CW:0]                    tab_dest;

	logic [RW-1:0]                  row_nxt;
	logic [CW-1:0]                  col_nxt;
	logic [RW-1:0]                  top_nxt;
	logic [ROWS-1:0]                valid_nxt;
	logic                           adv_row;

	// Logical row to stored row, rotated by the scroll offset
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
		input logic [RW-1:0] top);
		logic [RW:0] sum;
		sum = {1'b0, lr} + {1'b0, top};
		if (sum >= (RW + 1)'(ROWS)) begin
			sum = sum - (RW + 1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	assign printable   = (char_q inside {[tcce_pkg::CHAR_FIRST:tcce_pkg::CHAR_LAST]});
	assign rd_in_range = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLS);
	assign cur_phys    = phys_row(row_q, top_q);
	assign rd_phys     = phys_row(RW'(rrow_q), top_q);
	assign row_base    = AW'(32'(cur_phys) * COLS);
	assign raddr       = AW'(32'(rd_phys) * COLS + 32'(rcol_q));
	assign we          = cmd.fill_step || cmd.write_cell;
	assign waddr       = cmd.fill_step ? (row_base + AW'(fill_q)) : (row_base + AW'(col_q));
	assign wdata       = cmd.fill_step ? tcce_pkg::BLANK_CELL
	                                   : {1'b0, bg_q, fg_q, char_q};
	assign tab_dest    = tcce_pkg::next_tab(col_q);

	tcce_ram #(
		.WIDTH (tcce_pkg::CELL_W),
		.DEPTH (tcce_pkg::CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.read_issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Cursor update for one put byte
	always_comb begin
		row_nxt   = row_q;
		col_nxt   = col_q;
		top_nxt   = top_q;
		valid_nxt = row_valid_q;
		adv_row   = 1'b0;
		if (printable) begin
			if (col_q == CW'(COLS - 1)) begin
				col_nxt = '0;
				adv_row = 1'b1;
			end else begin
				col_nxt = col_q + CW'(1);
			end
		end else begin
			case (char_q)
				tcce_pkg::CHAR_BS: begin
					if (col_q != '0) begin
						col_nxt = col_q - CW'(1);
					end
				end
				tcce_pkg::CHAR_HT: begin
					if (tab_dest >= (CW + 1)'(COLS)) begin
						col_nxt = '0;
						adv_row = 1'b1;
					end else begin
						col_nxt = tab_dest[CW-1:0];
					end
				end
				tcce_pkg::CHAR_LF: begin
					adv_row = 1'b1;
				end
				tcce_pkg::CHAR_FF: begin
					row_nxt   = '0;
					col_nxt   = '0;
					valid_nxt = '0;
				end
				tcce_pkg::CHAR_CR: begin
					col_nxt = '0;
				end
				default: begin
				end
			endcase
		end
		if (adv_row) begin
			if (row_q == RW'(ROWS - 1)) begin
				// scroll: the old top row becomes the new bottom, blank on next touch
				top_nxt          = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
				valid_nxt[top_q] = 1'b0;
			end else begin
				row_nxt = row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q          <= '0;
			col_q          <= '0;
			top_q          <= '0;
			row_valid_q    <= '0;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				fill_q <= '0;
			end else if (cmd.fill_step) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.fill_step && status.fill_last) begin
				row_valid_q[cur_phys] <= 1'b1;
			end
			if (cmd.apply_put) begin
				row_q       <= row_nxt;
				col_q       <= col_nxt;
				top_q       <= top_nxt;
				row_valid_q <= valid_nxt;
			end
			if (cmd.load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			command_q <= command;
			char_q    <= char_code;
			fg_q      <= foreground;
			bg_q      <= background;
			rrow_q    <= read_row;
			rcol_q    <= read_column;
		end
		case (cmd.cell_sel)
			tcce_pkg::CELL_ZERO:  cell_q <= '0;
			tcce_pkg::CELL_BLANK: cell_q <= tcce_pkg::BLANK_CELL;
			tcce_pkg::CELL_RAM:   cell_q <= rdata;
			default: begin
			end
		endcase
		if (cmd.load_result) begin
			res_row_q  <= RFW'(row_q);
			res_col_q  <= CFW'(col_q);
			res_idx_q  <= IFW'(32'(row_q) * COLS + 32'(col_q));
			res_cell_q <= cell_q;
		end
	end

	always_comb begin
		status.is_read        = (command_q == tcce_pkg::CMD_READ);
		status.is_printable   = printable;
		status.row_valid      = row_valid_q[cur_phys];
		status.read_in_range  = rd_in_range;
		status.read_row_valid = row_valid_q[rd_phys];
		status.fill_last      = (fill_q == CW'(COLS - 1));
		status.out_free       = !result_valid_q || !result_stall;
	end

	assign result_valid  = result_valid_q;
	assign cursor_row    = res_row_q;
	assign cursor_column = res_col_q;
	assign cursor_index  = res_idx_q;
	assign cell_data     = res_cell_q;

endmodule

`default_nettype wire

@@ rtl/core/tcce_checker.sv @@
// Port-level checker for the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and the top level's ports.
`default_nettype none

module tcce_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	input  wire logic                                  item_stall,
	input  wire logic                                  result_valid,
	input  wire logic                                  result_stall,
	input  wire logic [tcce_pkg::ROW_FIELD_W-1:0]      cursor_row,
	input  wire logic [tcce_pkg::COL_FIELD_W-1:0]      cursor_column,
	input  wire logic [tcce_pkg::IDX_FIELD_W-1:0]      cursor_index
);

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(cursor_index))
		else $error("stalled result dropped or changed");

	// One transaction at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted while previous one in flight");

	// Cursor stays on screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(cursor_row) < tcce_pkg::ROWS)
		&& (32'(cursor_column) < tcce_pkg::COLUMNS))
		else $error("cursor off screen");

	// Linear index matches row and column
	a_cursor_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(cursor_index)
		== 32'(cursor_row) * tcce_pkg::COLUMNS + 32'(cursor_column))
		else $error("cursor index mismatch");

endmodule

bind text_console_cursor_engine tcce_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.cursor_row    (cursor_row),
	.cursor_column (cursor_column),
	.cursor_index  (cursor_index)
);

`default_nettype wire
